FILE: rtl/pcm_voice_mixer_unit_assert.svh
// ---------------------------------------------------------------------------
// PCM voice mixer assertion macros
// Short forms for the concurrent checks on the mixer ports.
// ---------------------------------------------------------------------------
`ifndef PCM_VOICE_MIXER_UNIT_ASSERT_SVH
`define PCM_VOICE_MIXER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PVM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pvm_pkg.sv
// ---------------------------------------------------------------------------
// PCM voice mixer package
// Field widths, action codes and mixing constants shared by the mixer files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvm_pkg;

    localparam int ACT_W       = 3;
    localparam int SID_W       = 8;
    localparam int ADDR_IN_W   = 16;
    localparam int LEN_W       = 17;
    localparam int BYTE_W      = 8;
    localparam int MIX_W       = 8;
    localparam int VOICE_OUT_W = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int MIX_TERM_W  = 10;

    localparam int PCM_BIAS = 'h80;
    localparam int MIX_MAX  = 'h7f;
    localparam int MIX_MIN  = -'h7f;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK     = 3'd0,
        ACT_PLAY     = 3'd1,
        ACT_STOP_ID  = 3'd2,
        ACT_STOP_ALL = 3'd3,
        ACT_WRITE    = 3'd4
    } pvm_action_t;

endpackage

FILE: rtl/pvm_addr_mod.sv
// ---------------------------------------------------------------------------
// PCM voice mixer address reduction
// Reduces a 16-bit address modulo the sample memory depth by reciprocal
// multiplication and one correcting subtract, or by truncation on the fast path.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvm_addr_mod
    import pvm_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ADDR_IN_W-1:0]             addr_in,
    output logic                             done,
    output logic [$clog2(SAMPLE_DEPTH)-1:0]  addr_mod
);

    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int RCP_W  = 25;
    localparam int PROD_W = ADDR_IN_W + RCP_W;
    localparam int QUO_W  = 8;
    localparam int QD_W   = 24;
    // Power-of-two depths truncate; depths above the address range pass through
    localparam bit FAST   = ((SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0) ||
                            (SAMPLE_DEPTH > 65535);
    // Depth reciprocal scaled by 2^32: the quotient it gives is exact or one short
    localparam longint unsigned     RCP_L   = (64'd1 << 32) / SAMPLE_DEPTH;
    localparam logic [RCP_W-1:0]    RCP_C   = RCP_W'(RCP_L);
    localparam logic [QD_W-1:0]     DEPTH_Q = QD_W'(SAMPLE_DEPTH);

    logic [AW-1:0]        rem_reg,  rem_next;
    logic [ADDR_IN_W-1:0] hold_reg, hold_next;
    logic [QUO_W-1:0]     quo_reg,  quo_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PROD_W-1:0]    prod;
    logic [QD_W-1:0]      part;
    logic [QD_W-1:0]      diff;

    always_comb
    begin
        rem_next  = rem_reg;
        hold_next = hold_reg;
        quo_next  = quo_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        prod      = PROD_W'(addr_in) * PROD_W'(RCP_C);
        part      = QD_W'(quo_reg) * DEPTH_Q;
        diff      = QD_W'(hold_reg) - part;
        if (start)
        begin
            if (FAST)
            begin
                rem_next  = AW'(addr_in);
                done_next = 1'b1;
            end
            else
            begin
                hold_next = addr_in;
                quo_next  = prod[32 +: QUO_W];
                busy_next = 1'b1;
                done_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            // Remainder lies below twice the depth: subtract the depth once if it fits
            if (diff >= DEPTH_Q)
                rem_next = AW'(diff - DEPTH_Q);
            else
                rem_next = AW'(diff);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        hold_reg <= hold_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign addr_mod = rem_reg;

endmodule

FILE: rtl/pcm_voice_mixer_unit.sv
// Path, accept to result: stop and unused items go through S_EXEC to S_RESULT; play
//   and write items first wait in S_MOD for the address reduction (multiply, then
//   correct, for a depth below 65536 that is not a power of two). Tick items go
//   through S_TICK: one voice-memory read a cycle, each followed by a sample-memory
//   read and an accumulate. One item at a time; the next is taken once the result
//   sits in the output register. Reset: async, active low; idles voices.
// ---------------------------------------------------------------------------
// PCM voice mixer top level
// Multi-voice 8-bit PCM mixer with sample memory, play/stop control and
// a saturated mix per tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_voice_mixer_unit
    import pvm_pkg::*;
#(
    parameter int VOICES       = 4,
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sound_id[7:0], start_address[23:8], length[40:24], sample_byte[48:41], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // mixed_sample[7:0], voice[9:8], no_voice[10], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW    = $clog2(VOICES + 1);
    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W = MIX_TERM_W + $clog2(VOICES);

    localparam logic signed [MIX_TERM_W-1:0] BIAS_S = MIX_TERM_W'(PCM_BIAS);
    localparam logic signed [SUM_W-1:0]      SAT_HI = SUM_W'(MIX_MAX);
    localparam logic signed [SUM_W-1:0]      SAT_LO = SUM_W'(MIX_MIN);

    // One-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD    = 5'b00010,
        S_EXEC   = 5'b00100,
        S_TICK   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    // Per-voice playback position kept in the voice memory
    typedef struct packed {
        logic [AW-1:0]    addr;
        logic [LEN_W-1:0] rem;
    } voice_ent_t;

    state_t state_reg, state_next;

    // Item fields, held from accept until the result is formed
    pvm_action_t          act_reg,  act_next;
    logic [SID_W-1:0]     sid_reg,  sid_next;
    logic [LEN_W-1:0]     len_reg,  len_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;

    // Voice flags and ids live in flops: stop by id compares all at once
    logic [VOICES-1:0]    active_reg, active_next;
    logic [SID_W-1:0]     vsid_reg  [VOICES];
    logic [SID_W-1:0]     vsid_next [VOICES];

    // Tick pipeline: issue voice read, then sample read, then accumulate
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 p1_vld_reg, p1_vld_next;
    logic [VW-1:0]        p1_idx_reg, p1_idx_next;
    logic                 p2_vld_reg, p2_vld_next;
    logic                 p2_act_reg, p2_act_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;

    // Result waiting for the output register
    logic [MIX_W-1:0]       res_mixed_reg, res_mixed_next;
    logic [VOICE_OUT_W-1:0] res_voice_reg, res_voice_next;
    logic                   res_none_reg,  res_none_next;

    // Output register
    logic                   out_vld_reg,   out_vld_next;
    logic [MIX_W-1:0]       out_mixed_reg, out_mixed_next;
    logic [VOICE_OUT_W-1:0] out_voice_reg, out_voice_next;
    logic                   out_none_reg,  out_none_next;

    // Memories
    voice_ent_t           vmem_mem [VOICES];
    voice_ent_t           vmem_rd_reg;
    logic                 vmem_we, vmem_re;
    logic [VW-1:0]        vmem_waddr, vmem_raddr;
    voice_ent_t           vmem_wdata;

    logic [BYTE_W-1:0]    smem_mem [SAMPLE_DEPTH];
    logic [BYTE_W-1:0]    smem_rd_reg;
    logic                 smem_we, smem_re;
    logic [AW-1:0]        smem_raddr;

    // Address reduction
    logic                 mod_start, mod_done;
    logic [AW-1:0]        mod_addr;

    logic                 in_beat, out_free;
    logic                 free_any;
    logic [VW-1:0]        free_idx;
    logic                 rd_issue, p1_act;
    logic [LEN_W-1:0]     rem_dec;
    logic [AW-1:0]        addr_inc;
    logic signed [MIX_TERM_W-1:0] term_half, term;
    logic [MIX_W-1:0]     sat_val;
    pvm_action_t          in_act;

    assign in_act   = pvm_action_t'(s_axis_tuser);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_vld_reg || m_axis_tready;

    // Play and write take the address modulo the memory depth
    assign mod_start = in_beat && ((in_act == ACT_PLAY) || (in_act == ACT_WRITE));

    pvm_addr_mod #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_addr_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .addr_in  (s_axis_tdata[23:8]),
        .done     (mod_done),
        .addr_mod (mod_addr)
    );

    // Lowest idle voice
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    // Voice step: advance address with wrap, count length down
    assign rem_dec  = vmem_rd_reg.rem - LEN_W'(1);
    assign addr_inc = (vmem_rd_reg.addr == AW'(SAMPLE_DEPTH - 1)) ? '0 :
                      vmem_rd_reg.addr + AW'(1);
    assign rd_issue = (rd_cnt_reg != CW'(VOICES));
    assign p1_act   = active_reg[p1_idx_reg];

    // Signed contribution (byte - bias) * 2
    assign term_half = $signed({2'b00, smem_rd_reg}) - BIAS_S;
    assign term      = term_half <<< 1;

    // Clamp the sum to the symmetric output range
    always_comb
    begin
        if (acc_reg > SAT_HI)
            sat_val = MIX_W'(SAT_HI);
        else if (acc_reg < SAT_LO)
            sat_val = MIX_W'(SAT_LO);
        else
            sat_val = MIX_W'(acc_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        sid_next       = sid_reg;
        len_next       = len_reg;
        byte_next      = byte_reg;
        active_next    = active_reg;
        vsid_next      = vsid_reg;
        rd_cnt_next    = rd_cnt_reg;
        p1_vld_next    = p1_vld_reg;
        p1_idx_next    = p1_idx_reg;
        p2_vld_next    = p2_vld_reg;
        p2_act_next    = p2_act_reg;
        acc_next       = acc_reg;
        res_mixed_next = res_mixed_reg;
        res_voice_next = res_voice_reg;
        res_none_next  = res_none_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        out_mixed_next = out_mixed_reg;
        out_voice_next = out_voice_reg;
        out_none_next  = out_none_reg;
        vmem_we        = 1'b0;
        vmem_waddr     = free_idx;
        vmem_wdata     = '{addr: mod_addr, rem: len_reg};
        vmem_re        = 1'b0;
        vmem_raddr     = rd_cnt_reg[VW-1:0];
        smem_we        = 1'b0;
        smem_re        = 1'b0;
        smem_raddr     = vmem_rd_reg.addr;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    act_next  = in_act;
                    sid_next  = s_axis_tdata[7:0];
                    len_next  = s_axis_tdata[40:24];
                    byte_next = s_axis_tdata[48:41];
                    state_next = mod_start ? S_MOD : S_EXEC;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                res_mixed_next = '0;
                res_voice_next = '0;
                res_none_next  = 1'b0;
                state_next     = S_RESULT;
                case (act_reg)
                    ACT_TICK:
                    begin
                        rd_cnt_next = '0;
                        p1_vld_next = 1'b0;
                        p2_vld_next = 1'b0;
                        acc_next    = '0;
                        state_next  = S_TICK;
                    end
                    ACT_PLAY:
                    begin
                        res_none_next = 1'b1;
                        if ((len_reg != '0) && free_any)
                        begin
                            vmem_we               = 1'b1;
                            active_next[free_idx] = 1'b1;
                            vsid_next[free_idx]   = sid_reg;
                            res_voice_next        = VOICE_OUT_W'(free_idx);
                            res_none_next         = 1'b0;
                        end
                    end
                    ACT_STOP_ID:
                    begin
                        // Idle ids match whether active or not
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (vsid_reg[i] == sid_reg)
                                active_next[i] = 1'b0;
                        end
                    end
                    ACT_STOP_ALL:
                    begin
                        active_next = '0;
                    end
                    ACT_WRITE:
                    begin
                        smem_we = 1'b1;
                    end
                    default:
                    begin
                        // Unused codes: change nothing, answer zeros
                    end
                endcase
            end

            S_TICK:
            begin
                // Issue one voice-memory read a cycle
                if (rd_issue)
                begin
                    vmem_re     = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                p1_vld_next = rd_issue;
                p1_idx_next = rd_cnt_reg[VW-1:0];

                // Voice entry back: fetch its byte, write the stepped entry back
                p2_vld_next = p1_vld_reg;
                p2_act_next = p1_vld_reg && p1_act;
                if (p1_vld_reg && p1_act)
                begin
                    smem_re    = 1'b1;
                    vmem_we    = 1'b1;
                    vmem_waddr = p1_idx_reg;
                    vmem_wdata = '{addr: addr_inc, rem: rem_dec};
                    if (rem_dec == '0)
                        active_next[p1_idx_reg] = 1'b0;
                end

                // Sample byte back: accumulate
                if (p2_vld_reg && p2_act_reg)
                    acc_next = acc_reg + SUM_W'(term);

                if (!rd_issue && !p1_vld_reg && !p2_vld_reg)
                begin
                    res_mixed_next = sat_val;
                    state_next     = S_RESULT;
                end
            end

            S_RESULT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_mixed_next = res_mixed_reg;
                    out_voice_next = res_voice_reg;
                    out_none_next  = res_none_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            active_reg  <= '0;
            rd_cnt_reg  <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p2_act_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
                vsid_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            rd_cnt_reg  <= rd_cnt_next;
            p1_vld_reg  <= p1_vld_next;
            p2_vld_reg  <= p2_vld_next;
            p2_act_reg  <= p2_act_next;
            out_vld_reg <= out_vld_next;
            vsid_reg    <= vsid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        sid_reg       <= sid_next;
        len_reg       <= len_next;
        byte_reg      <= byte_next;
        p1_idx_reg    <= p1_idx_next;
        acc_reg       <= acc_next;
        res_mixed_reg <= res_mixed_next;
        res_voice_reg <= res_voice_next;
        res_none_reg  <= res_none_next;
        out_mixed_reg <= out_mixed_next;
        out_voice_reg <= out_voice_next;
        out_none_reg  <= out_none_next;
    end

    // Voice memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (vmem_we)
            vmem_mem[vmem_waddr] <= vmem_wdata;
        if (vmem_re)
            vmem_rd_reg <= vmem_mem[vmem_raddr];
    end

    // Sample memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (smem_we)
            smem_mem[mod_addr] <= byte_reg;
        if (smem_re)
            smem_rd_reg <= smem_mem[smem_raddr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - MIX_W - VOICE_OUT_W - 1)'(0),
                            out_none_reg, out_voice_reg, out_mixed_reg};

endmodule

FILE: rtl/pvm_checker.sv
// ---------------------------------------------------------------------------
// PCM voice mixer port checker
// Concurrent checks on the mixer ports, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcm_voice_mixer_unit_assert.svh"

module pvm_checker
    import pvm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [ACT_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat holds
    `PVM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "result beat changed while stalled")

    // One item at a time: no input beat right after one is taken
    `PVM_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "input taken while an item is in work")

    // A refused play carries no voice and no sample; the mix never reaches -128
    `PVM_ASSERT(a_result_shape, (m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80) && (!m_axis_tdata[10] || (m_axis_tdata[9:0] == 10'd0)) && (m_axis_tdata[15:11] == 5'd0)), "malformed result beat")

    // No result beat during reset
    `PVM_ASSERT_ALWAYS(a_reset_quiet, (!rst_n |-> !m_axis_tvalid), "result valid in reset")

endmodule

bind pcm_voice_mixer_unit pvm_checker u_pvm_checker (.*);
